>>> rtl/midi_note_event_encoder_top_macros.svh
// assertion helpers, clocked on clk and disabled during rst
`ifndef MIDI_NOTE_EVENT_ENCODER_TOP_MACROS_SVH
`define MIDI_NOTE_EVENT_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MNEE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MNEE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MNEE_ASSERT_NOW(label, ante, cons)
`define MNEE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/mnee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mnee_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned DIV_W = 18;
  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned DIV_STEPS = 32 / DIV_STAGES;

  localparam logic [23:0] TEMPO_RESET = 24'd500000;
  localparam logic [9:0] MS_SCALE = 10'd1000;
  // floor(x / 3) = (x * RECIP3) >> 21 for x below 2^21
  localparam logic [19:0] RECIP3 = 20'd699051;
  localparam logic [31:0] VLQ_MAX = 32'h0FFF_FFFF;
  localparam logic [7:0] STATUS_ON = 8'h90;
  localparam logic [7:0] STATUS_OFF = 8'h80;
  localparam logic [7:0] VLQ_FULL = 8'hFF;
  localparam logic [7:0] VLQ_TAIL = 8'h7F;

  typedef struct packed {
    logic cmd;
    logic [3:0] channel;
    logic [31:0] delay_ms;
    logic [7:0] note_number;
    logic [7:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic last_byte;
  } out_item_t;

  // one encoded event: bytes[0] goes out first, len is 4 to 7
  typedef struct packed {
    logic [6:0][7:0] bytes;
    logic [2:0] len;
  } ev_t;

endpackage

`default_nettype wire

>>> rtl/mnee_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mnee_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire mnee_pkg::in_item_t item,
  input  wire logic               cfg_valid,
  input  wire logic [23:0]        cfg_data,
  output logic                    ev_valid,
  input  wire logic               ev_ready,
  output mnee_pkg::ev_t           ev
);
  import mnee_pkg::*;

  typedef struct packed {
    logic cmd;
    logic [3:0] channel;
    logic [7:0] note_number;
    logic [7:0] velocity;
  } pass_t;

  typedef struct packed {
    logic [31:0] dq;
    logic [DIV_W-1:0] rem;
  } div_t;

  // DIV_STEPS restoring steps; dq shifts dividend out and quotient in
  function automatic div_t div_chunk(input logic [31:0] dq_in, input logic [DIV_W-1:0] rem_in,
                                     input logic [DIV_W-1:0] d);
    logic [31:0] q;
    logic [DIV_W:0] r;
    logic [DIV_W-1:0] rr;
    div_t res;
    q = dq_in;
    rr = rem_in;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {rr, q[31]};
      q = {q[30:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
      rr = r[DIV_W-1:0];
    end
    res.dq = q;
    res.rem = rr;
    return res;
  endfunction

  logic [23:0] tempo;
  logic [41:0] scale_prod;
  logic [38:0] recip_prod;
  logic [DIV_W-1:0] divisor;
  logic en;

  logic [DIV_STAGES:0] s_valid;
  logic [31:0] s_dq [DIV_STAGES+1];
  logic [DIV_W-1:0] s_rem [DIV_STAGES+1];
  logic [DIV_W-1:0] s_div [DIV_STAGES+1];
  logic [DIV_STAGES:0] s_sat;
  pass_t s_pass [DIV_STAGES+1];

  logic [31:0] quo;
  logic big;
  logic [6:0] grp [4];
  logic [2:0] n;
  logic [7:0] status;
  ev_t ev_next;

  assign en = !ev_valid || ev_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo <= TEMPO_RESET;
    end else if (cfg_valid) begin
      tempo <= cfg_data;
    end
  end

  // delay * 1000 keeps its low 32 bits; divisor = (tempo / 32) / 3
  assign scale_prod = {10'b0, item.delay_ms} * {32'b0, MS_SCALE};
  assign recip_prod = {20'b0, tempo[23:5]} * {19'b0, RECIP3};
  assign divisor = recip_prod[38:21];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (en) begin
      s_valid[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_dq[0] <= scale_prod[31:0];
      s_rem[0] <= '0;
      s_div[0] <= divisor;
      s_sat[0] <= (divisor == '0);
      s_pass[0] <= '{cmd: item.cmd, channel: item.channel,
                     note_number: item.note_number, velocity: item.velocity};
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    div_t step;
    assign step = div_chunk(s_dq[k-1], s_rem[k-1], s_div[k-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[k] <= 1'b0;
      end else if (en) begin
        s_valid[k] <= s_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_dq[k] <= step.dq;
        s_rem[k] <= step.rem;
        s_div[k] <= s_div[k-1];
        s_sat[k] <= s_sat[k-1];
        s_pass[k] <= s_pass[k-1];
      end
    end
  end

  // classify: length of the quantity, then lay out the whole event
  assign quo = s_dq[DIV_STAGES];
  assign big = s_sat[DIV_STAGES] || (quo > VLQ_MAX);
  assign status = (s_pass[DIV_STAGES].cmd ? STATUS_ON : STATUS_OFF)
                  | {4'h0, s_pass[DIV_STAGES].channel};

  always_comb begin
    grp[0] = quo[6:0];
    grp[1] = quo[13:7];
    grp[2] = quo[20:14];
    grp[3] = quo[27:21];
    if (big || grp[3] != '0) begin
      n = 3'd4;
    end else if (grp[2] != '0) begin
      n = 3'd3;
    end else if (grp[1] != '0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    ev_next = '0;
    for (int i = 0; i < 4; i++) begin
      if (big) begin
        ev_next.bytes[i] = (i == 3) ? VLQ_TAIL : VLQ_FULL;
      end else if (3'(i) < n) begin
        ev_next.bytes[i] = {(3'(i) != n - 3'd1), grp[2'(n - 3'd1 - 3'(i))]};
      end
    end
    ev_next.bytes[n] = status;
    ev_next.bytes[n + 3'd1] = s_pass[DIV_STAGES].note_number;
    ev_next.bytes[n + 3'd2] = s_pass[DIV_STAGES].velocity;
    ev_next.len = n + 3'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (en) begin
      ev_valid <= s_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ev <= ev_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mnee_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mnee_queue #(
  parameter int unsigned DEPTH = mnee_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mnee_pkg::ev_t in_ev,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mnee_pkg::ev_t      out_ev
);
  import mnee_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ev_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_ev = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_ev;
    end
  end

`include "midi_note_event_encoder_top_macros.svh"

  `MNEE_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `MNEE_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1)
  `MNEE_ASSERT_NEXT(a_count_down, pop && !push, count == $past(count) - 1'b1)

endmodule

`default_nettype wire

>>> rtl/mnee_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mnee_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ev_valid,
  output logic               ev_ready,
  input  wire mnee_pkg::ev_t ev,
  output logic               result_valid,
  input  wire logic          result_ready,
  output mnee_pkg::out_item_t result
);
  import mnee_pkg::*;

  logic [2:0] idx;
  logic load;
  logic is_last;

  assign load = ev_valid && (!result_valid || result_ready);
  assign is_last = (idx == ev.len - 3'd1);
  assign ev_ready = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      idx <= is_last ? '0 : idx + 3'd1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte <= ev.bytes[idx];
      result.last_byte <= is_last;
    end
  end

`include "midi_note_event_encoder_top_macros.svh"

  `MNEE_ASSERT_NOW(a_len_range, ev_valid, ev.len >= 3'd4)
  `MNEE_ASSERT_NOW(a_idx_range, ev_valid, idx < ev.len)
  `MNEE_ASSERT_NEXT(a_idx_clear, ev_ready, idx == '0 && result_valid && result.last_byte)

endmodule

`default_nettype wire

>>> rtl/midi_note_event_encoder_top.sv
// channel  | handshake               | payload
// item     | item_valid/item_ready   | in_item_t: cmd, channel, delay_ms, note_number, velocity
// result   | result_valid/result_ready | out_item_t: out_byte, last_byte
// cfg      | cfg_valid/cfg_ready     | cfg_data: quarter note microseconds
// one item enters per cycle unless stalled; 4 to 7 result bytes leave per item at one byte
//   a cycle while result_ready holds, so the back-end byte sequencer sets the sustained rate
// from accept to first byte an item passes the input register, the divide stages,
//   the classify register, the queue and the result register
// rst is synchronous; it empties the pipeline and queue and loads the tempo 500000
// a stalled result backs up into the queue and then holds the divide pipeline;
//   cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module midi_note_event_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = mnee_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire mnee_pkg::in_item_t  item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output mnee_pkg::out_item_t      result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [23:0]         cfg_data
);
  import mnee_pkg::*;

  // classified events between front end and queue
  logic f_valid;
  logic f_ready;
  ev_t f_ev;

  // queue to byte sequencer
  logic q_valid;
  logic q_ready;
  ev_t q_ev;

  // tempo register always takes a write
  assign cfg_ready = 1'b1;

  // front end: scale, pipelined divide, vlq classify
  mnee_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .ev_valid   (f_valid),
    .ev_ready   (f_ready),
    .ev         (f_ev)
  );

  // short queue so the sequencer and the divider stall independently
  mnee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_ev     (f_ev),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_ev    (q_ev)
  );

  // back end: one byte per cycle into the result register unless the result is stalled
  mnee_back u_back (
    .clk          (clk),
    .rst          (rst),
    .ev_valid     (q_valid),
    .ev_ready     (q_ready),
    .ev           (q_ev),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> tb/midi_note_event_encoder_top_test.sv
`timescale 1ns / 1ps

module midi_note_event_encoder_top_test;

  // midi timing constants, kept apart from the design package
  localparam logic [23:0] TICKS_PER_BEAT = 24'd96;
  localparam logic [31:0] MS_TO_US = 32'd1000;
  localparam logic [31:0] VLQ_LIMIT = 32'h0FFF_FFFF;
  localparam logic [7:0] NOTE_ON = 8'h90;
  localparam logic [7:0] NOTE_OFF = 8'h80;
  localparam logic [7:0] VLQ_SAT_HEAD = 8'hFF;
  localparam logic [7:0] VLQ_SAT_TAIL = 8'h7F;
  localparam logic [23:0] TEMPO_AT_RESET = 24'd500000;
  localparam logic [23:0] TEMPO_MAX = 24'hFF_FFFF;

  // cycles the pipeline may still need after the last byte, plus margin
  localparam int SETTLE_CYCLES = mnee_pkg::DIV_STAGES + 3 + 8;
  localparam int CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic item_valid = 1'b0;
  logic item_ready;
  mnee_pkg::in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  mnee_pkg::out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_data = '0;

  // note events waiting to be offered, and bytes the encoder still owes us
  mnee_pkg::in_item_t pending_events[$];
  mnee_pkg::out_item_t expected_bytes[$];

  // our copy of the tempo register
  logic [23:0] tempo_model = TEMPO_AT_RESET;

  // when set, neither side idles
  bit steady_flow = 1'b0;

  int mismatch_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;

  midi_note_event_encoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void expect_byte(input logic [7:0] value, input logic last);
    mnee_pkg::out_item_t b;
    b.out_byte = value;
    b.last_byte = last;
    expected_bytes.push_back(b);
  endfunction

  // delay -> ticks -> variable-length quantity, then status, note, velocity
  function automatic void encode_event(input mnee_pkg::in_item_t ev);
    logic [23:0] divisor;
    logic [31:0] scaled;
    logic [31:0] ticks;
    logic saturate;
    int groups;
    int g;
    divisor = tempo_model / TICKS_PER_BEAT;
    scaled = ev.delay_ms * MS_TO_US;  // wraps at 32 bits
    ticks = '0;
    saturate = (divisor == 0);
    if (!saturate) begin
      ticks = scaled / divisor;
      saturate = (ticks > VLQ_LIMIT);
    end
    if (saturate) begin
      expect_byte(VLQ_SAT_HEAD, 1'b0);
      expect_byte(VLQ_SAT_HEAD, 1'b0);
      expect_byte(VLQ_SAT_HEAD, 1'b0);
      expect_byte(VLQ_SAT_TAIL, 1'b0);
    end else begin
      // no empty leading groups, continuation bit on all but the last
      groups = 1;
      while (groups < 4 && (ticks >> (7 * groups)) != 0) groups++;
      for (g = groups - 1; g >= 0; g--) expect_byte({g != 0, ticks[7*g +: 7]}, 1'b0);
    end
    expect_byte((ev.cmd ? NOTE_ON : NOTE_OFF) | {4'h0, ev.channel}, 1'b0);
    expect_byte(ev.note_number, 1'b0);
    expect_byte(ev.velocity, 1'b1);
  endfunction

  function automatic mnee_pkg::in_item_t make_event(input logic cmd, input logic [3:0] channel,
                                                    input logic [31:0] delay_ms,
                                                    input logic [7:0] note_number,
                                                    input logic [7:0] velocity);
    mnee_pkg::in_item_t ev;
    ev.cmd = cmd;
    ev.channel = channel;
    ev.delay_ms = delay_ms;
    ev.note_number = note_number;
    ev.velocity = velocity;
    return ev;
  endfunction

  // delays are drawn from bands that hit short, long, saturating and wrapping counts
  function automatic mnee_pkg::in_item_t random_event();
    logic [31:0] delay_ms;
    case ($urandom_range(0, 5))
      0: delay_ms = $urandom;
      1: delay_ms = $urandom_range(0, 300);
      2: delay_ms = $urandom_range(0, 5_000_000);
      3: delay_ms = $urandom_range(4_294_000, 4_295_500);   // around the scaling wrap
      4: delay_ms = $urandom_range(268_000, 269_000);       // around saturation at divisor 1
      default: delay_ms = $urandom_range(0, 3000);
    endcase
    return make_event(1'($urandom), 4'($urandom), delay_ms, 8'($urandom), 8'($urandom));
  endfunction

  task automatic send_random(input int count);
    repeat (count) pending_events.push_back(random_event());
  endtask

  // sender holds off until every owed byte is back and the pipeline has emptied
  task automatic wait_idle();
    do @(negedge clk); while (pending_events.size() != 0 || item_valid ||
                              expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_tempo(input logic [23:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tempo_model = value;
  endtask

  // note event driver: expectations are formed at the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (item_valid && item_ready) encode_event(item);
      if (!item_valid || item_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          item_valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          item <= pending_events.pop_front();
          item_valid <= 1'b1;
          send_gap <= steady_flow ? 0 : random_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor: random back-pressure, each accepted byte checked in order
  always @(posedge clk) begin : byte_monitor
    mnee_pkg::out_item_t want;
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 4) == 0) stall_left <= random_gap();
      end
      if (result_valid && result_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte %h arrived with no event outstanding", result.out_byte);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, result.out_byte);
            mismatch_count++;
          end
          if (result.last_byte !== want.last_byte) begin
            $error("last_byte expected %b actual %b", want.last_byte, result.last_byte);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset tempo, divisor 5208: zero count, wrap, field extremes
    pending_events.push_back(make_event(1'b0, 4'h0, 32'd0, 8'h00, 8'h00));
    pending_events.push_back(make_event(1'b1, 4'hF, 32'd1, 8'hFF, 8'hFF));
    pending_events.push_back(make_event(1'b1, 4'h5, 32'hFFFF_FFFF, 8'h3C, 8'h40));
    pending_events.push_back(make_event(1'b0, 4'hA, 32'd4_294_967, 8'h80, 8'h7F));
    pending_events.push_back(make_event(1'b1, 4'h3, 32'd4_294_968, 8'h01, 8'h80));
    pending_events.push_back(make_event(1'b0, 4'hC, 32'd665_000, 8'h55, 8'hAA));
    send_random(15);
    wait_idle();

    // divisor 1: every quantity length and the saturation edge
    write_tempo(TICKS_PER_BEAT);
    pending_events.push_back(make_event(1'b1, 4'h1, 32'd0, 8'h40, 8'h64));
    pending_events.push_back(make_event(1'b1, 4'h2, 32'd16, 8'h41, 8'h64));
    pending_events.push_back(make_event(1'b0, 4'h3, 32'd17, 8'h42, 8'h00));
    pending_events.push_back(make_event(1'b1, 4'h4, 32'd2097, 8'h43, 8'h10));
    pending_events.push_back(make_event(1'b0, 4'h6, 32'd2098, 8'h44, 8'h20));
    pending_events.push_back(make_event(1'b1, 4'h7, 32'd268_435, 8'h45, 8'h30));
    pending_events.push_back(make_event(1'b0, 4'h8, 32'd268_436, 8'h46, 8'h40));
    pending_events.push_back(make_event(1'b1, 4'h9, 32'hFFFF_FFFF, 8'h47, 8'h50));
    send_random(25);
    wait_idle();

    // zero divisor, both at the bottom and just below one tick
    write_tempo(24'd0);
    pending_events.push_back(make_event(1'b1, 4'hB, 32'd0, 8'h3C, 8'h7F));
    pending_events.push_back(make_event(1'b0, 4'hD, 32'd5, 8'h3C, 8'h00));
    send_random(8);
    wait_idle();
    write_tempo(24'd95);
    pending_events.push_back(make_event(1'b1, 4'hE, 32'd1, 8'h24, 8'h60));
    send_random(5);
    wait_idle();

    // largest tempo
    write_tempo(TEMPO_MAX);
    pending_events.push_back(make_event(1'b1, 4'hF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    pending_events.push_back(make_event(1'b0, 4'h0, 32'd174, 8'h00, 8'h01));
    send_random(15);
    wait_idle();

    // small tempo, sender pauses halfway for everything to come back
    write_tempo(24'($urandom_range(96, 20000)));
    send_random(12);
    wait_idle();
    send_random(13);
    wait_idle();

    // any tempo, no idling on either side
    steady_flow = 1'b1;
    write_tempo(24'($urandom));
    send_random(25);
    wait_idle();
    steady_flow = 1'b0;

    // back near the reset tempo with idling again
    write_tempo(TEMPO_AT_RESET + 24'd1);
    send_random(13);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mnee_pkg.sv
rtl/mnee_front.sv
rtl/mnee_queue.sv
rtl/mnee_back.sv
rtl/midi_note_event_encoder_top.sv
tb/midi_note_event_encoder_top_test.sv
